// ----- hdl/ctt_pkg.sv -----
// Shared types and constants for the truth-table fill block.
`timescale 1ns / 1ps

package ctt_pkg;

    // Table word geometry
    localparam int WORD_LOG  = 6;
    localparam int WORD_BITS = 64;
    localparam logic [WORD_LOG-1:0] LOW_FIELD = 6'h3F;

    // Input field widths
    localparam int NV_W    = 5;
    localparam int CUBE_W  = 16;
    localparam int WIDX_W  = 10;

    // Item operation codes
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        B_INIT,
        B_IDLE,
        B_CLEAR,
        B_ADD,
        B_READ,
        B_DONE
    } back_state_t;

endpackage

// ----- hdl/ctt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ctt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/ctt_fifo.sv -----
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps

module ctt_fifo #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign dout      = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- hdl/ctt_front.sv -----
// Front end: config register, item accept and cube decode into a command.
`timescale 1ns / 1ps

module ctt_front import ctt_pkg::*; #(
    parameter int MAX_VARS    = 16,
    parameter int AW          = 10,
    parameter int TABLE_WORDS = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [NV_W-1:0]      cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           op,
    input  logic [CUBE_W-1:0]    cube_mask,
    input  logic [CUBE_W-1:0]    cube_values,
    input  logic [WIDX_W-1:0]    word_index,
    input  logic                 q_full,
    input  logic                 clearing,
    output logic                 q_push,
    output op_t                  c_op,
    output logic [WORD_BITS-1:0] c_pattern,
    output logic [AW-1:0]        c_last,
    output logic [AW-1:0]        c_hmask,
    output logic [AW-1:0]        c_hvals,
    output logic [AW-1:0]        c_raddr,
    output logic                 c_oob
);

    logic [NV_W-1:0]   num_vars_reg;
    logic [NV_W-1:0]   n_eff;
    logic [CUBE_W-1:0] varmask;
    logic [CUBE_W-1:0] mask16;
    logic [CUBE_W-1:0] vals16;

    // Variable count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_vars_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            num_vars_reg <= cfg_wr_data;
        end
    end

    // Accept when the queue has room and the reset sweep is over
    assign in_ready = !q_full && !clearing;
    assign q_push   = in_valid && in_ready;

    // Cube decode: low six variables give the in-word pattern, the rest pick words
    always_comb
    begin
        n_eff   = (num_vars_reg > NV_W'(MAX_VARS)) ? NV_W'(MAX_VARS) : num_vars_reg;
        varmask = (n_eff >= NV_W'(CUBE_W)) ? {CUBE_W{1'b1}}
                                           : CUBE_W'((32'd1 << n_eff) - 32'd1);
        mask16  = cube_mask & varmask;
        vals16  = cube_values & mask16;

        c_op = op_t'(op);

        for (int b = 0; b < WORD_BITS; b++)
        begin
            c_pattern[b] = ((n_eff >= NV_W'(WORD_LOG)) || (b < (32'd1 << n_eff)))
                && (((WORD_LOG'(b) ^ vals16[WORD_LOG-1:0]) & mask16[WORD_LOG-1:0]
                     & LOW_FIELD) == '0);
        end

        c_last  = (n_eff < NV_W'(WORD_LOG)) ? '0
                : AW'((32'd1 << (n_eff - NV_W'(WORD_LOG))) - 32'd1);
        c_hmask = AW'(32'(mask16) >> WORD_LOG);
        c_hvals = AW'(32'(vals16) >> WORD_LOG);
        c_raddr = AW'(32'(word_index));
        c_oob   = (32'(word_index) >= 32'(TABLE_WORDS));
    end

endmodule

// ----- hdl/ctt_back.sv -----
// Back end: sequencer that clears, fills and reads the table memory.
`timescale 1ns / 1ps

module ctt_back import ctt_pkg::*; #(
    parameter int AW          = 10,
    parameter int TABLE_WORDS = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  op_t                  q_op,
    input  logic [WORD_BITS-1:0] q_pattern,
    input  logic [AW-1:0]        q_last,
    input  logic [AW-1:0]        q_hmask,
    input  logic [AW-1:0]        q_hvals,
    input  logic [AW-1:0]        q_raddr,
    input  logic                 q_oob,
    output logic                 clearing,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [WORD_BITS-1:0] read_word
);

    localparam logic [AW-1:0] LAST_WORD = AW'(TABLE_WORDS - 1);

    back_state_t          state_reg, state_next;
    logic [AW-1:0]        cnt_reg, cnt_next;
    logic [WORD_BITS-1:0] pattern_reg;
    logic [AW-1:0]        last_reg, hmask_reg, hvals_reg;
    logic                 oob_reg;
    logic                 pend_valid_reg, pend_valid_next;
    logic                 pend_match_reg, pend_match_next;
    logic [AW-1:0]        pend_addr_reg, pend_addr_next;
    logic [WORD_BITS-1:0] res_reg, res_next;
    logic                 out_valid_reg;
    logic [WORD_BITS-1:0] read_word_reg;
    logic                 load_out;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    ctt_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (TABLE_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign clearing  = (state_reg == B_INIT);
    assign out_valid = out_valid_reg;
    assign read_word = read_word_reg;

    // Next state, memory control and result
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        q_pop           = 1'b0;
        pend_valid_next = 1'b0;
        pend_match_next = 1'b0;
        pend_addr_next  = cnt_reg;
        res_next        = res_reg;
        load_out        = 1'b0;
        ram_raddr       = cnt_reg;

        // Write back of the word read in the previous cycle
        ram_we    = pend_valid_reg && pend_match_reg;
        ram_waddr = pend_addr_reg;
        ram_wdata = ram_rdata | pattern_reg;

        case (state_reg)
            B_INIT, B_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = '0;
                if (cnt_reg == LAST_WORD)
                begin
                    cnt_next   = '0;
                    state_next = (state_reg == B_INIT) ? B_IDLE : B_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            B_IDLE:
            begin
                ram_raddr = q_raddr;
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cnt_next = '0;
                    res_next = '0;
                    case (q_op)
                        OP_CLEAR: state_next = B_CLEAR;
                        OP_ADD:   state_next = B_ADD;
                        OP_READ:  state_next = B_READ;
                        default:  state_next = B_DONE;
                    endcase
                end
            end
            B_ADD:
            begin
                pend_valid_next = 1'b1;
                pend_match_next = (((cnt_reg ^ hvals_reg) & hmask_reg) == '0);
                if (cnt_reg == last_reg)
                begin
                    state_next = B_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            B_READ:
            begin
                res_next   = oob_reg ? '0 : ram_rdata;
                state_next = B_DONE;
            end
            B_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_INIT;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_match_reg <= pend_match_next;
        pend_addr_reg  <= pend_addr_next;
        res_reg        <= res_next;
        if (q_pop)
        begin
            pattern_reg <= q_pattern;
            last_reg    <= q_last;
            hmask_reg   <= q_hmask;
            hvals_reg   <= q_hvals;
            oob_reg     <= q_oob;
        end
        if (load_out)
        begin
            read_word_reg <= res_reg;
        end
    end

    // Checks
    a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("command popped from an empty queue");

    a_no_pop_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_INIT) |-> !q_pop)
        else $error("command taken during the reset sweep");

    a_pend_in_add: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == B_ADD || state_reg == B_DONE))
        else $error("word write-back outside a cube fill");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == B_DONE))
        else $error("result presented without finishing a command");

endmodule

// ----- hdl/cube_truth_table_fill.sv -----
// Top level of the cube to truth-table fill block.
//
// Holds a truth table of 2^MAX_VARS bits in 64-bit words. Items arrive on a
// valid/ready input channel (op, cube_mask, cube_values, word_index); every
// item gives one beat on the valid/ready output channel (read_word), which is
// the addressed word for a read and zero otherwise. num_vars is written
// through cfg_wr_en / cfg_wr_data; the user must do this only while the
// block is idle, as the block itself does not enforce it. Items pass
// through a two-entry command queue to a sequencer that owns a
// single-port-write, registered-read table memory, one word per cycle.
// An add cube walks 2^(num_vars-6) table words (1 below six variables),
// a clear walks all TABLE_WORDS words, a read fetches the addressed word
// and a nop touches no memory; the sequencer ends each item before it
// pops the next one from the queue.
// After reset a sweep zeroes all TABLE_WORDS table words (1024 at
// the default), during which in_ready stays low. A stalled output holds its
// beat; the sequencer finishes one more item and waits, and the queue takes
// up to two items behind it before in_ready drops.
`timescale 1ns / 1ps

module cube_truth_table_fill import ctt_pkg::*; #(
    parameter int MAX_VARS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [NV_W-1:0]      cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           op,
    input  logic [CUBE_W-1:0]    cube_mask,
    input  logic [CUBE_W-1:0]    cube_values,
    input  logic [WIDX_W-1:0]    word_index,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [WORD_BITS-1:0] read_word
);

    localparam int TABLE_WORDS = 1 << (MAX_VARS - WORD_LOG);
    localparam int AW          = (MAX_VARS > WORD_LOG) ? (MAX_VARS - WORD_LOG) : 1;
    localparam int CW          = 2 + WORD_BITS + 4 * AW + 1;

    logic                 q_push, q_full, q_pop, q_valid, clearing;
    logic [CW-1:0]        q_din, q_dout;
    op_t                  c_op, d_op;
    logic [WORD_BITS-1:0] c_pattern, d_pattern;
    logic [AW-1:0]        c_last, c_hmask, c_hvals, c_raddr;
    logic [AW-1:0]        d_last, d_hmask, d_hvals, d_raddr;
    logic                 c_oob, d_oob;

    ctt_front #(
        .MAX_VARS    (MAX_VARS),
        .AW          (AW),
        .TABLE_WORDS (TABLE_WORDS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .cube_mask   (cube_mask),
        .cube_values (cube_values),
        .word_index  (word_index),
        .q_full      (q_full),
        .clearing    (clearing),
        .q_push      (q_push),
        .c_op        (c_op),
        .c_pattern   (c_pattern),
        .c_last      (c_last),
        .c_hmask     (c_hmask),
        .c_hvals     (c_hvals),
        .c_raddr     (c_raddr),
        .c_oob       (c_oob)
    );

    // Command packing through the queue
    assign q_din = {c_op, c_pattern, c_last, c_hmask, c_hvals, c_raddr, c_oob};

    ctt_fifo #(
        .WIDTH (CW)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .din       (q_din),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .dout      (q_dout)
    );

    always_comb
    begin
        d_op      = op_t'(q_dout[CW-1 -: 2]);
        d_pattern = q_dout[CW-3 -: WORD_BITS];
        d_last    = q_dout[4*AW : 3*AW+1];
        d_hmask   = q_dout[3*AW : 2*AW+1];
        d_hvals   = q_dout[2*AW : AW+1];
        d_raddr   = q_dout[AW : 1];
        d_oob     = q_dout[0];
    end

    ctt_back #(
        .AW          (AW),
        .TABLE_WORDS (TABLE_WORDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_op      (d_op),
        .q_pattern (d_pattern),
        .q_last    (d_last),
        .q_hmask   (d_hmask),
        .q_hvals   (d_hvals),
        .q_raddr   (d_raddr),
        .q_oob     (d_oob),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .read_word (read_word)
    );

endmodule
